// ----- rtl/ksub_pkg.sv -----
// Shared types, constants and helpers for the Koch segment subdivider.
`default_nettype none

package ksub_pkg;

    localparam int COORD_W   = 24;
    localparam int MAX_DEPTH = 3;
    localparam int DEPTH_W   = 2;
    localparam int LEVEL_W   = 2;
    localparam int NUM_CHILD = 4;
    localparam int CHILD_W   = 2;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(2);

    // Shared multiplier: signed 28 x 29 bits.
    localparam int MUL_A_W = COORD_W + 4;
    localparam int MUL_B_W = 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // floor(u / 3) = (u * ceil(2^29 / 3)) >> 29, exact for u below 2^27.
    localparam int RECIP_SHIFT = 29;
    localparam logic signed [MUL_B_W-1:0] RECIP_THIRD = 29'sh0AAA_AAAB;
    localparam logic signed [MUL_B_W-1:0] SIN60_Q16   = 29'sh0000_DDB4;

    // Thirds numerator is biased by 3 * 2^23 + 1 so that it is always positive.
    localparam int THIRD_W = COORD_W + 3;

    // Apex sum: Q16 fraction, cosine of 0.5 is a shift by 15.
    localparam int Q16_FRAC  = 16;
    localparam int COS_SHIFT = 15;
    localparam int SUM_W     = COORD_W + 19;
    localparam int SAT_IN_W  = SUM_W - Q16_FRAC;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SPLIT,
        ST_ASCEND
    } ksub_state_t;

    typedef enum logic [2:0] {
        STEP_P2X,
        STEP_P4X,
        STEP_P2Y,
        STEP_P4Y,
        STEP_VX,
        STEP_VY,
        STEP_TX
    } step_t;

    // Clamp a wide signed value into the coordinate range.
    function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
        coord_t r;
        if (&v[SAT_IN_W-1:COORD_W-1] || ~|v[SAT_IN_W-1:COORD_W-1]) begin
            r = v[COORD_W-1:0];
        end
        else if (v[SAT_IN_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ksub_split_unit.sv -----
// Split unit: computes the one-third points and the apex of a segment on one shared multiplier.
`default_nettype none

module ksub_split_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ksub_pkg::point_t seg_a,
    input  wire ksub_pkg::point_t seg_b,
    output logic                  done,
    output ksub_pkg::point_t      p2,
    output ksub_pkg::point_t      apex,
    output ksub_pkg::point_t      p4
);
    import ksub_pkg::*;

    localparam logic signed [THIRD_W-1:0] THIRD_BIAS =
        THIRD_W'(3 * (1 << (COORD_W - 1)) + 1);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (Q16_FRAC - 1));

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    step_t step_reg, step_next;

    logic signed [PROD_W-1:0]  prod_reg;
    point_t                    p2_reg, p4_reg, apex_reg;

    logic                      use_y;
    coord_t                    near_c, far_c;
    logic signed [THIRD_W-1:0] third_num;
    logic signed [COORD_W:0]   vx, vy;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    coord_t                    third_q;
    logic signed [SUM_W-1:0]   tx_sum, ty_sum;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        use_y  = (step_reg == STEP_P2Y) || (step_reg == STEP_P4Y);
        near_c = use_y ? seg_a.y : seg_a.x;
        far_c  = use_y ? seg_b.y : seg_b.x;
        if ((step_reg == STEP_P4X) || (step_reg == STEP_P4Y))
        begin
            third_num = THIRD_W'(near_c) + (THIRD_W'(far_c) <<< 1) + THIRD_BIAS;
        end
        else
        begin
            third_num = (THIRD_W'(near_c) <<< 1) + THIRD_W'(far_c) + THIRD_BIAS;
        end

        vx = (COORD_W+1)'(p4_reg.x) - (COORD_W+1)'(p2_reg.x);
        vy = (COORD_W+1)'(p4_reg.y) - (COORD_W+1)'(p2_reg.y);

        case (step_reg)
            STEP_VX:
            begin
                mul_a = MUL_A_W'(vx);
                mul_b = SIN60_Q16;
            end
            STEP_VY:
            begin
                mul_a = MUL_A_W'(vy);
                mul_b = SIN60_Q16;
            end
            default:
            begin
                mul_a = MUL_A_W'(third_num);
                mul_b = RECIP_THIRD;
            end
        endcase
    end

    // Post-processing of the registered product. The bias of 2^23 comes off
    // as a flip of the top bit.
    always_comb
    begin
        third_q = {~prod_reg[RECIP_SHIFT+COORD_W-1],
                   prod_reg[RECIP_SHIFT+COORD_W-2:RECIP_SHIFT]};
        ty_sum  = (SUM_W'(p2_reg.y) <<< Q16_FRAC) - SUM_W'(prod_reg)
                + (SUM_W'(vy) <<< COS_SHIFT) + ROUND_HALF;
        tx_sum  = (SUM_W'(p2_reg.x) <<< Q16_FRAC) + SUM_W'(prod_reg)
                + (SUM_W'(vx) <<< COS_SHIFT) + ROUND_HALF;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = STEP_P2X;
            end
        end
        else if (step_reg == STEP_TX)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            step_next = STEP_P2X;
        end
        else
        begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_P2X;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Each step issues one product and writes back the one issued in the step before.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (busy_reg)
        begin
            case (step_reg)
                STEP_P4X: p2_reg.x   <= third_q;
                STEP_P2Y: p4_reg.x   <= third_q;
                STEP_P4Y: p2_reg.y   <= third_q;
                STEP_VX:  p4_reg.y   <= third_q;
                STEP_VY:  apex_reg.y <= sat_coord(ty_sum[SUM_W-1:Q16_FRAC]);
                STEP_TX:  apex_reg.x <= sat_coord(tx_sum[SUM_W-1:Q16_FRAC]);
                default:  ;
            endcase
        end
    end

    assign done = done_reg;
    assign p2   = p2_reg;
    assign apex = apex_reg;
    assign p4   = p4_reg;

endmodule

`default_nettype wire

// ----- rtl/koch_segment_subdivider.sv -----
// Koch segment subdivider top level: traversal sequencer, level stack and output register.
// Each split runs on the shared multiplier, each leaf segment is loaded into the output
// register, and each finished split level passes through an ascend state; output stalls add to this.
// Reset clears the sequencer and output valid and sets the depth register to 2.
`default_nettype none

module koch_segment_subdivider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        edge_valid,
    output logic                             edge_stall,
    input  wire ksub_pkg::coord_t            edge_start_x,
    input  wire ksub_pkg::coord_t            edge_start_y,
    input  wire ksub_pkg::coord_t            edge_end_x,
    input  wire ksub_pkg::coord_t            edge_end_y,
    output logic                             segment_valid,
    input  wire logic                        segment_stall,
    output ksub_pkg::coord_t                 segment_start_x,
    output ksub_pkg::coord_t                 segment_start_y,
    output ksub_pkg::coord_t                 segment_end_x,
    output ksub_pkg::coord_t                 segment_end_y,
    output logic                             last_segment,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ksub_pkg::DEPTH_W-1:0] subdivision_depth
);
    import ksub_pkg::*;

    ksub_state_t          state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    point_t               seg_a_reg, seg_a_next;
    point_t               seg_b_reg, seg_b_next;

    // Level stack: entry 0 is the innermost split level. Each entry keeps the
    // points still to be visited, with the end of the running child in front.
    point_t               stk_pts_reg  [MAX_DEPTH][NUM_CHILD];
    point_t               stk_pts_next [MAX_DEPTH][NUM_CHILD];
    logic [CHILD_W-1:0]   stk_left_reg  [MAX_DEPTH];
    logic [CHILD_W-1:0]   stk_left_next [MAX_DEPTH];

    logic                 out_valid_reg, out_valid_next;
    point_t               out_a_reg, out_b_reg;
    logic                 out_last_reg;

    logic [LEVEL_W-1:0]   eff_depth;
    logic                 leaf;
    logic                 out_free;
    logic                 last_flag;
    logic                 load_out;
    logic                 finish;
    logic                 split_start;
    logic                 split_done;
    point_t               split_p2, split_apex, split_p4;

    ksub_split_unit u_split (
        .clk   (clk),
        .rst_n (rst_n),
        .start (split_start),
        .seg_a (seg_a_reg),
        .seg_b (seg_b_reg),
        .done  (split_done),
        .p2    (split_p2),
        .apex  (split_apex),
        .p4    (split_p4)
    );

    always_comb
    begin
        eff_depth = (depth_reg > LEVEL_W'(MAX_DEPTH)) ? LEVEL_W'(MAX_DEPTH) : depth_reg;
        leaf      = (level_reg >= eff_depth);
        out_free  = !out_valid_reg || !segment_stall;
        // The segment is the last one when every open level runs its last child.
        last_flag = 1'b1;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((LEVEL_W'(i) < level_reg) && (stk_left_reg[i] != '0))
            begin
                last_flag = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        seg_a_next    = seg_a_reg;
        seg_b_next    = seg_b_reg;
        stk_pts_next  = stk_pts_reg;
        stk_left_next = stk_left_reg;
        split_start   = 1'b0;
        load_out      = 1'b0;
        finish        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (edge_valid)
                begin
                    seg_a_next = '{x: edge_start_x, y: edge_start_y};
                    seg_b_next = '{x: edge_end_x, y: edge_end_y};
                    level_next = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (leaf)
                begin
                    if (out_free)
                    begin
                        load_out = 1'b1;
                        finish   = 1'b1;
                    end
                end
                else
                begin
                    split_start = 1'b1;
                    state_next  = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (split_done)
                begin
                    for (int i = MAX_DEPTH - 1; i > 0; i--)
                    begin
                        stk_pts_next[i]  = stk_pts_reg[i-1];
                        stk_left_next[i] = stk_left_reg[i-1];
                    end
                    stk_pts_next[0][0] = split_p2;
                    stk_pts_next[0][1] = split_apex;
                    stk_pts_next[0][2] = split_p4;
                    stk_pts_next[0][3] = seg_b_reg;
                    stk_left_next[0]   = CHILD_W'(NUM_CHILD - 1);
                    seg_b_next         = split_p2;
                    level_next         = level_reg + 1'b1;
                    state_next         = ST_DECIDE;
                end
            end
            ST_ASCEND:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A segment at this level is done: at level 0 return to idle, else move to the next sibling,
        // or close the level and let the parent finish in the following cycle.
        if (finish)
        begin
            if (level_reg == '0)
            begin
                state_next = ST_IDLE;
            end
            else if (stk_left_reg[0] == '0)
            begin
                for (int i = 0; i < MAX_DEPTH - 1; i++)
                begin
                    stk_pts_next[i]  = stk_pts_reg[i+1];
                    stk_left_next[i] = stk_left_reg[i+1];
                end
                stk_left_next[MAX_DEPTH-1] = '0;
                level_next = level_reg - 1'b1;
                state_next = ST_ASCEND;
            end
            else
            begin
                seg_a_next = stk_pts_reg[0][0];
                seg_b_next = stk_pts_reg[0][1];
                for (int k = 0; k < NUM_CHILD - 1; k++)
                begin
                    stk_pts_next[0][k] = stk_pts_reg[0][k+1];
                end
                stk_left_next[0] = stk_left_reg[0] - 1'b1;
                state_next       = ST_DECIDE;
            end
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (cfg_valid)
        begin
            depth_next = subdivision_depth;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (segment_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            depth_reg     <= DEPTH_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                stk_left_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            stk_left_reg  <= stk_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_a_reg   <= seg_a_next;
        seg_b_reg   <= seg_b_next;
        stk_pts_reg <= stk_pts_next;
        if (load_out)
        begin
            out_a_reg    <= seg_a_reg;
            out_b_reg    <= seg_b_reg;
            out_last_reg <= last_flag;
        end
    end

    assign edge_stall      = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign segment_valid   = out_valid_reg;
    assign segment_start_x = out_a_reg.x;
    assign segment_start_y = out_a_reg.y;
    assign segment_end_x   = out_b_reg.x;
    assign segment_end_y   = out_b_reg.y;
    assign last_segment    = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/ksub_checker.sv -----
// Port-level checker for the Koch segment subdivider and its bind to the top level.
`default_nettype none

module ksub_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        edge_valid,
    input wire logic                        edge_stall,
    input wire logic                        segment_valid,
    input wire logic                        segment_stall,
    input wire ksub_pkg::coord_t            segment_start_x,
    input wire ksub_pkg::coord_t            segment_start_y,
    input wire ksub_pkg::coord_t            segment_end_x,
    input wire ksub_pkg::coord_t            segment_end_y,
    input wire logic                        last_segment
);
    import ksub_pkg::*;

    // A stalled segment stays put until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        segment_valid && segment_stall |=>
            segment_valid && $stable(segment_start_x) && $stable(segment_start_y)
            && $stable(segment_end_x) && $stable(segment_end_y) && $stable(last_segment))
        else $error("segment changed while stalled");

    // Once an edge is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && !edge_stall |=> edge_stall)
        else $error("edge input not stalled after an edge transfer");

    // More segments of the current edge are still to come, so no new edge is taken.
    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        segment_valid && !last_segment |-> edge_stall)
        else $error("edge input open while an edge is unfinished");

    // A new edge starts only after every segment but the last has left.
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && !edge_stall |-> !segment_valid || last_segment)
        else $error("edge transfer while earlier segments are pending");

endmodule

bind koch_segment_subdivider ksub_checker u_ksub_checker (.*);

`default_nettype wire
